### rtl/ptc_pkg.sv
// ptc_pkg: shared widths, constants, codes and types of the transport clock
// no dependencies; imported by every module of the block
`default_nettype none

package ptc_pkg;

  localparam int POS_W   = 40;
  localparam int TIME_W  = 48;
  localparam int IV_W    = 20;
  localparam int SR_W    = 19;
  localparam int FR_W    = 20;
  localparam int FP_W    = 32;
  localparam int DIV_W   = 52;
  localparam int DVS_W   = 20;
  localparam int CNT_W   = 6;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 64;

  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [FP_W-1:0]   FP_MAX   = {FP_W{1'b1}};

  localparam int SLEW_US  = 1000;
  localparam int SNAP_US  = 40000;
  localparam int US_PER_S = 1000000;
  localparam int IV_MIN   = 1000;
  localparam int IV_MAX   = 1000000;

  localparam logic [IV_W-1:0] IV_RESET = IV_W'(20000);
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(48000);

  // event actions
  localparam logic [2:0] ACT_PLAY   = 3'd0;
  localparam logic [2:0] ACT_PAUSE  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_SEEK   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;
  localparam logic [2:0] ACT_PUSHED = 3'd5;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_NOTHING = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_HALT    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // register indexes (8-byte spacing)
  localparam logic [1:0] REG_SEQ_END  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_RATE     = 2'd2;
  localparam logic [1:0] REG_AUDIO    = 2'd3;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_PLAYING = 2'd1,
    TS_PAUSED  = 2'd2
  } tstate_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_APPLY,
    SQ_RAW,
    SQ_MUL,
    SQ_DIVA_GO,
    SQ_DIVA_WAIT,
    SQ_APOS,
    SQ_POS,
    SQ_DIVD_GO,
    SQ_DIVD_WAIT,
    SQ_DDL,
    SQ_FIN
  } seq_t;

  typedef struct packed {
    logic [POS_W-1:0] seq_end;
    logic [IV_W-1:0]  frame_period;
    logic [SR_W-1:0]  audio_rate;
    logic             audio_real;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [IV_W-1:0] clamp_iv(input logic [IV_W-1:0] iv);
    if (iv < IV_W'(IV_MIN)) begin
      return IV_W'(IV_MIN);
    end else if (iv > IV_W'(IV_MAX)) begin
      return IV_W'(IV_MAX);
    end
    return iv;
  endfunction

endpackage

`default_nettype wire

### rtl/ptc_if.sv
// ptc_evt_if, ptc_res_if: valid/ready channels of the transport clock
// depends on ptc_pkg for field widths
`default_nettype none

interface ptc_evt_if;
  import ptc_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [TIME_W-1:0] now_us;
  logic [POS_W-1:0]  seek_pos;
  logic [FR_W-1:0]   queued_frames;
  logic [FR_W-1:0]   pushed_count;
  modport source (output valid, action, now_us, seek_pos, queued_frames,
                  pushed_count, input ready);
  modport sink (input valid, action, now_us, seek_pos, queued_frames,
                pushed_count, output ready);
endinterface

interface ptc_res_if;
  import ptc_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  play_pos;
  logic [1:0]        play_state;
  logic [1:0]        event_code;
  logic [TIME_W-1:0] next_deadline_us;
  logic              notify;
  logic [1:0]        stream_cmd;
  modport source (output valid, play_pos, play_state, event_code, next_deadline_us,
                  notify, stream_cmd, input ready);
  modport sink (input valid, play_pos, play_state, event_code, next_deadline_us,
                notify, stream_cmd, output ready);
endinterface

`default_nettype wire

### rtl/ptc_cfg.sv
// ptc_cfg: apb register file of the transport clock
// depends on ptc_pkg
`default_nettype none

module ptc_cfg import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_end      <= '0;
      cfg.frame_period <= IV_RESET;
      cfg.audio_rate   <= SR_RESET;
      cfg.audio_real   <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_SEQ_END:  cfg.seq_end      <= pwdata[POS_W-1:0];
        REG_INTERVAL: cfg.frame_period <= pwdata[IV_W-1:0];
        REG_RATE:     cfg.audio_rate   <= pwdata[SR_W-1:0];
        REG_AUDIO:    cfg.audio_real   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEQ_END:  prdata = APB_DW'(cfg.seq_end);
      REG_INTERVAL: prdata = APB_DW'(cfg.frame_period);
      REG_RATE:     prdata = APB_DW'(cfg.audio_rate);
      REG_AUDIO:    prdata = APB_DW'(cfg.audio_real);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ptc_div.sv
// ptc_div: restoring divider, one quotient bit per cycle
// depends on ptc_pkg; shared by the audio and deadline paths
`default_nettype none

module ptc_div import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] work;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign trial = {rem, work[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], qbit};
      rem  <= qbit ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

### rtl/playback_transport_clock.sv
// playback_transport_clock: media transport clock, sequencer and datapath
// depends on ptc_pkg, ptc_if, ptc_cfg, ptc_div
//
// channel  dir  beat
// evt      in   action, now_us, seek_pos, queued_frames, pushed_count
// res      out  play_pos, play_state, event_code, next_deadline_us, notify,
//                stream_cmd
// apb      in   register writes and reads, no wait states
//
// an event passes idle, apply, raw and fin when not playing, with pos added
// when playing; an audio-corrected position adds mul, diva_go, diva_wait and
// apos, and a playing tick adds divd_go, divd_wait and ddl, both waits spent
// in the shared 52-bit divider (one quotient bit a cycle).
// evt.ready is high only while the sequencer is idle; a finished result
// waits in the output register and the next event can be taken meanwhile,
// but a second result stalls the sequencer until the first one leaves.
// rst is synchronous and resets the sequencer, transport state and apb registers
`default_nettype none

module playback_transport_clock import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ptc_evt_if.sink           evt,
  ptc_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  div_req_t dreq;
  div_rsp_t drsp;
  seq_t     seq, seq_next;

  ptc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ptc_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  // latched event
  logic [2:0]        act;
  logic [TIME_W-1:0] now_r;
  logic [POS_W-1:0]  seek_r;
  logic [FR_W-1:0]   queued_r;
  logic [FR_W-1:0]   pushed_r;

  // transport state
  tstate_t           tstate;
  logic [POS_W-1:0]  parked;
  logic [POS_W-1:0]  anc_pos;
  logic [TIME_W-1:0] anc_time;
  logic [POS_W-1:0]  base_pos;
  logic [FP_W-1:0]   frames;

  // work registers
  logic [TIME_W:0]   raw;
  logic [FP_W-1:0]   consumed;
  logic [DIV_W-1:0]  prod;
  logic [DIV_W:0]    apos;
  logic signed [55:0] diff;
  logic [POS_W-1:0]  pos_calc;
  logic [TIME_W-1:0] ddl;
  logic              elap_neg;
  logic [1:0]        ev_code;
  logic              notify_r;
  logic [1:0]        cmd;
  logic              have_pos;

  logic              audio;
  logic              out_free;
  logic [IV_W-1:0]   iv_eff;

  assign audio    = cfg.audio_real & (cfg.audio_rate != '0);
  assign out_free = ~res.valid | res.ready;
  assign iv_eff   = clamp_iv(cfg.frame_period);
  assign evt.ready = (seq == SQ_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // elapsed time since the anchor, for the deadline division
  logic signed [TIME_W+1:0] elapsed;
  logic [TIME_W+1:0]        elap_mag;
  assign elapsed  = $signed({2'b00, now_r}) - $signed({2'b00, anc_time});
  assign elap_mag = elapsed[TIME_W+1] ? (TIME_W+2)'(-elapsed) : (TIME_W+2)'(elapsed);

  always_comb begin
    seq_next      = seq;
    dreq.start    = 1'b0;
    dreq.dividend = prod;
    dreq.divisor  = DVS_W'(cfg.audio_rate);
    case (seq)
      SQ_IDLE:      if (evt.valid) seq_next = SQ_APPLY;
      SQ_APPLY:     seq_next = SQ_RAW;
      SQ_RAW: begin
        if (tstate != TS_PLAYING) begin
          seq_next = SQ_FIN;
        end else if (audio) begin
          seq_next = SQ_MUL;
        end else begin
          seq_next = SQ_POS;
        end
      end
      SQ_MUL:       seq_next = SQ_DIVA_GO;
      SQ_DIVA_GO: begin
        dreq.start = 1'b1;
        seq_next   = SQ_DIVA_WAIT;
      end
      SQ_DIVA_WAIT: if (drsp.done) seq_next = SQ_APOS;
      SQ_APOS:      seq_next = SQ_POS;
      SQ_POS:       seq_next = (act == ACT_TICK) ? SQ_DIVD_GO : SQ_FIN;
      SQ_DIVD_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(elap_mag);
        dreq.divisor  = iv_eff;
        seq_next      = SQ_DIVD_WAIT;
      end
      SQ_DIVD_WAIT: if (drsp.done) seq_next = SQ_DDL;
      SQ_DDL:       seq_next = SQ_FIN;
      SQ_FIN:       if (out_free) seq_next = SQ_IDLE;
      default:      seq_next = SQ_IDLE;
    endcase
  end

  // combinational helpers for individual states
  logic [POS_W-1:0]   seek_cl;
  logic [FP_W:0]      fsum;
  logic signed [50:0] raw_s;
  logic signed [33:0] cons_s;
  logic signed [55:0] drift_v;
  logic signed [55:0] raw56;
  logic [TIME_W+1:0]  ddl_v;

  assign seek_cl = (seek_r > cfg.seq_end) ? cfg.seq_end : seek_r;
  assign fsum    = {1'b0, frames} + (FP_W+1)'(pushed_r);
  assign raw_s   = $signed({11'b0, anc_pos}) + $signed({3'b0, now_r})
                 - $signed({3'b0, anc_time});
  assign cons_s  = $signed({2'b0, frames}) - $signed({14'b0, queued_r});
  assign raw56   = $signed({7'b0, raw});

  always_comb begin
    if (diff > 56'sd40000 || diff < -56'sd40000) begin
      drift_v = $signed({3'b0, apos});
    end else if (diff > 56'sd1000) begin
      drift_v = raw56 + 56'sd1000;
    end else if (diff < -56'sd1000) begin
      drift_v = raw56 - 56'sd1000;
    end else begin
      drift_v = $signed({3'b0, apos});
    end
  end

  assign ddl_v = elap_neg ? ({2'b0, now_r} + (TIME_W+2)'(iv_eff) + (TIME_W+2)'(drsp.rem))
                          : ({2'b0, now_r} + (TIME_W+2)'(iv_eff) - (TIME_W+2)'(drsp.rem));

  // result beat and state update applied when the sequencer finishes
  logic [POS_W-1:0]  fin_pos;
  logic [1:0]        fin_ev;
  logic [TIME_W-1:0] fin_ddl;
  logic              fin_notify;
  logic [1:0]        fin_cmd;
  tstate_t           fin_state;
  logic [POS_W-1:0]  fin_parked;

  always_comb begin
    fin_pos    = (tstate == TS_PLAYING && !have_pos) ? pos_calc : parked;
    fin_ev     = ev_code;
    fin_ddl    = ddl;
    fin_notify = notify_r;
    fin_cmd    = cmd;
    fin_state  = tstate;
    fin_parked = parked;
    case (act)
      ACT_PAUSE: begin
        if (tstate == TS_PLAYING) begin
          fin_parked = pos_calc;
          fin_state  = TS_PAUSED;
          fin_pos    = pos_calc;
          fin_notify = 1'b1;
          fin_cmd    = CMD_HALT;
        end
      end
      ACT_STOP: begin
        if (tstate != TS_STOPPED) begin
          if (tstate == TS_PLAYING) begin
            fin_parked = pos_calc;
            fin_pos    = pos_calc;
          end
          fin_state  = TS_STOPPED;
          fin_notify = 1'b1;
          fin_cmd    = CMD_HALT;
        end
      end
      ACT_TICK: begin
        if (tstate == TS_PLAYING) begin
          fin_notify = 1'b1;
          if (pos_calc >= cfg.seq_end) begin
            fin_state  = TS_STOPPED;
            fin_parked = cfg.seq_end;
            fin_pos    = cfg.seq_end;
            fin_ev     = EV_END;
            fin_cmd    = CMD_HALT;
            fin_ddl    = now_r;
          end else begin
            fin_parked = pos_calc;
            fin_pos    = pos_calc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate    <= TS_STOPPED;
      parked    <= '0;
      anc_pos   <= '0;
      anc_time  <= '0;
      base_pos  <= '0;
      frames    <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && seq != SQ_FIN) res.valid <= 1'b0;
      case (seq)
        SQ_IDLE: begin
          if (evt.valid) begin
            act      <= evt.action;
            now_r    <= evt.now_us;
            seek_r   <= evt.seek_pos;
            queued_r <= evt.queued_frames;
            pushed_r <= evt.pushed_count;
            ev_code  <= EV_NONE;
            notify_r <= 1'b0;
            cmd      <= CMD_NONE;
            have_pos <= 1'b0;
            ddl      <= evt.now_us;
          end
        end
        SQ_APPLY: begin
          case (act)
            ACT_PLAY: begin
              if (cfg.seq_end == '0) begin
                ev_code <= EV_NOTHING;
              end else if (tstate != TS_PLAYING) begin
                anc_pos  <= parked;
                anc_time <= now_r;
                base_pos <= parked;
                frames   <= '0;
                tstate   <= TS_PLAYING;
                notify_r <= 1'b1;
                cmd      <= CMD_RESTART;
              end
            end
            ACT_SEEK: begin
              parked   <= seek_cl;
              notify_r <= 1'b1;
              have_pos <= 1'b1;
              if (tstate == TS_PLAYING) begin
                anc_pos  <= seek_cl;
                anc_time <= now_r;
                base_pos <= seek_cl;
                frames   <= '0;
                cmd      <= CMD_RESTART;
              end
            end
            ACT_PUSHED: frames <= fsum[FP_W] ? FP_MAX : fsum[FP_W-1:0];
            default: ;
          endcase
        end
        SQ_RAW: begin
          raw      <= raw_s[50] ? '0 : raw_s[TIME_W:0];
          consumed <= cons_s[33] ? '0 : cons_s[FP_W-1:0];
        end
        SQ_MUL:  prod <= DIV_W'(consumed * IV_W'(US_PER_S));
        SQ_APOS: begin
          apos <= (DIV_W+1)'(base_pos) + (DIV_W+1)'(drsp.quot);
          diff <= $signed({3'b0, (DIV_W+1)'(base_pos) + (DIV_W+1)'(drsp.quot)}) - raw56;
        end
        SQ_POS: begin
          if (audio) begin
            if (drift_v < 0) begin
              pos_calc <= '0;
            end else if (drift_v > $signed({16'b0, POS_MAX})) begin
              pos_calc <= POS_MAX;
            end else begin
              pos_calc <= drift_v[POS_W-1:0];
            end
          end else begin
            pos_calc <= (raw > (TIME_W+1)'(POS_MAX)) ? POS_MAX : raw[POS_W-1:0];
          end
        end
        SQ_DIVD_GO: elap_neg <= elapsed[TIME_W+1];
        SQ_DDL:     ddl <= (ddl_v > (TIME_W+2)'(TIME_MAX)) ? TIME_MAX : ddl_v[TIME_W-1:0];
        SQ_FIN: begin
          if (out_free) begin
            res.valid            <= 1'b1;
            res.event_code       <= fin_ev;
            res.next_deadline_us <= fin_ddl;
            res.notify           <= fin_notify;
            res.stream_cmd       <= fin_cmd;
            res.play_state       <= fin_state;
            res.play_pos         <= fin_pos;
            tstate               <= fin_state;
            parked               <= fin_parked;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
